[hw/rtl/skbh_pkg.sv]
// ----------------------------------------------------------------------------
// skbh_pkg
// Shared types and constants for the string key bucket hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package skbh_pkg;

    localparam int HASH_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int STEP_W         = $clog2(HASH_W);
    localparam int QUEUE_DEPTH    = 4;
    localparam logic [HASH_W-1:0] BUCKET_COUNT_RST = 32'd255;

    // mixing shift amounts
    localparam int MIX_SHL = 10;
    localparam int MIX_SHR = 6;
    localparam int FIN_SHL_A = 3;
    localparam int FIN_SHR = 11;
    localparam int FIN_SHL_B = 15;

    typedef logic [HASH_W-1:0] hash_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // status of the queue as seen by the back end
    typedef struct packed {
        logic  empty;
        hash_t head;
    } queue_stat_t;

endpackage

`default_nettype wire

[hw/rtl/skbh_front.sv]
// ----------------------------------------------------------------------------
// skbh_front
// Accepts key bytes, keeps the running hash and finalizes it at end of key.
// ----------------------------------------------------------------------------
`default_nettype none

module skbh_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [skbh_pkg::BYTE_W-1:0] key_byte,
    input  wire logic                        byte_valid,
    input  wire logic                        end_of_key,
    output logic                             push_valid,
    output skbh_pkg::hash_t                  push_hash,
    input  wire logic                        push_ready
);

    skbh_pkg::hash_t run_hash_reg;
    skbh_pkg::hash_t run_hash_next;
    skbh_pkg::hash_t pend_hash_reg;
    skbh_pkg::hash_t pend_hash_next;
    logic            pend_valid_reg;
    logic            pend_valid_next;
    skbh_pkg::hash_t mix_sum;
    skbh_pkg::hash_t mix_add;
    skbh_pkg::hash_t mixed;
    skbh_pkg::hash_t fin_a;
    skbh_pkg::hash_t fin_b;
    logic            accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !pend_valid_reg || push_ready;

    // add byte, then h += h<<10, h ^= h>>6
    always_comb
    begin
        mix_sum = run_hash_reg + skbh_pkg::hash_t'(key_byte);
        mix_add = mix_sum + (mix_sum << skbh_pkg::MIX_SHL);
        mixed   = byte_valid ? (mix_add ^ (mix_add >> skbh_pkg::MIX_SHR)) : run_hash_reg;
    end

    always_comb
    begin
        run_hash_next   = run_hash_reg;
        pend_hash_next  = pend_hash_reg;
        pend_valid_next = pend_valid_reg;
        if (push_ready)
        begin
            pend_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (end_of_key)
            begin
                run_hash_next   = '0;
                pend_hash_next  = mixed;
                pend_valid_next = 1'b1;
            end
            else
            begin
                run_hash_next = mixed;
            end
        end
    end

    // finalization on the held end-of-key hash
    always_comb
    begin
        fin_a     = pend_hash_reg + (pend_hash_reg << skbh_pkg::FIN_SHL_A);
        fin_b     = fin_a ^ (fin_a >> skbh_pkg::FIN_SHR);
        push_hash = fin_b + (fin_b << skbh_pkg::FIN_SHL_B);
    end

    assign push_valid = pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            run_hash_reg   <= run_hash_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hash_reg <= pend_hash_next;
    end

endmodule

`default_nettype wire

[hw/rtl/skbh_queue.sv]
// ----------------------------------------------------------------------------
// skbh_queue
// Small register queue of finalized hashes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module skbh_queue #(
    parameter int DEPTH = skbh_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire skbh_pkg::hash_t  push_hash,
    output logic                  push_ready,
    input  wire logic             pop,
    output skbh_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    skbh_pkg::hash_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign stat.empty = (count_reg == '0);
    assign stat.head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_hash;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/skbh_back.sv]
// ----------------------------------------------------------------------------
// skbh_back
// Reduces a finalized hash modulo a nonzero bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skbh_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire skbh_pkg::queue_stat_t stat,
    output logic                       pop,
    input  wire skbh_pkg::hash_t       bucket_count,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output skbh_pkg::hash_t            bucket_index,
    output skbh_pkg::hash_t            full_hash
);

    localparam logic [skbh_pkg::STEP_W-1:0] STEP_LAST = skbh_pkg::STEP_W'(skbh_pkg::HASH_W - 1);

    skbh_pkg::back_state_t        state_reg;
    skbh_pkg::back_state_t        state_next;
    skbh_pkg::hash_t              hash_reg;
    skbh_pkg::hash_t              hash_next;
    skbh_pkg::hash_t              dvd_reg;
    skbh_pkg::hash_t              dvd_next;
    skbh_pkg::hash_t              dvs_reg;
    skbh_pkg::hash_t              dvs_next;
    logic [skbh_pkg::HASH_W:0]    rem_reg;
    logic [skbh_pkg::HASH_W:0]    rem_next;
    logic [skbh_pkg::HASH_W:0]    rem_shift;
    logic [skbh_pkg::HASH_W:0]    rem_step;
    logic [skbh_pkg::STEP_W-1:0]  step_reg;
    logic [skbh_pkg::STEP_W-1:0]  step_next;
    logic                         start;
    logic                         last_step;

    // restoring division step, quotient bits are dropped
    always_comb
    begin
        rem_shift = {rem_reg[skbh_pkg::HASH_W-1:0], dvd_reg[skbh_pkg::HASH_W-1]};
        if (rem_shift >= {1'b0, dvs_reg})
        begin
            rem_step = rem_shift - {1'b0, dvs_reg};
        end
        else
        begin
            rem_step = rem_shift;
        end
    end

    assign start     = (state_reg == skbh_pkg::BK_IDLE) && !stat.empty;
    assign last_step = (step_reg == STEP_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skbh_pkg::BK_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = (bucket_count == '0) ? skbh_pkg::BK_DONE : skbh_pkg::BK_DIV;
                end
            end
            skbh_pkg::BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = skbh_pkg::BK_DONE;
                end
            end
            skbh_pkg::BK_DONE:
            begin
                if (out_ready)
                begin
                    state_next = skbh_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = skbh_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = start;
        out_valid = (state_reg == skbh_pkg::BK_DONE);
    end

    always_comb
    begin
        hash_next = hash_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start)
        begin
            hash_next = stat.head;
            dvd_next  = stat.head;
            dvs_next  = bucket_count;
            step_next = '0;
            // zero bucket count passes the hash through
            rem_next  = (bucket_count == '0) ? {1'b0, stat.head} : '0;
        end
        else if (state_reg == skbh_pkg::BK_DIV)
        begin
            rem_next  = rem_step;
            dvd_next  = dvd_reg << 1;
            step_next = step_reg + 1'b1;
        end
    end

    assign bucket_index = rem_reg[skbh_pkg::HASH_W-1:0];
    assign full_hash    = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skbh_pkg::BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
    end

endmodule

`default_nettype wire

[hw/rtl/string_key_bucket_hasher_top.sv]
// ----------------------------------------------------------------------------
// string_key_bucket_hasher_top
// One-at-a-time key hash with reduction to a bucket number.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | key_byte, byte_valid, end_of_key
//  out      | out_valid / out_ready| bucket_index, full_hash
//  cfg      | cfg_valid / cfg_ready| cfg_data (bucket_count)
//
//  key bytes are taken one per cycle while in_ready is high; an end-of-key
//  request is finalized in the next cycle and queued once the queue has room.
//  the bucket reduction is a one-bit-per-cycle remainder unit; a zero bucket
//  count passes the hash through. the next hash is taken from the queue only
//  after out_ready has taken the current result. reset clears the running
//  hash, the queue and sets bucket_count to 255. the input stalls only when
//  the hash queue is full; the back end holds a finished result until out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module string_key_bucket_hasher_top #(
    parameter int QUEUE_DEPTH = skbh_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [skbh_pkg::BYTE_W-1:0] key_byte,
    input  wire logic                        byte_valid,
    input  wire logic                        end_of_key,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [skbh_pkg::HASH_W-1:0]      bucket_index,
    output logic [skbh_pkg::HASH_W-1:0]      full_hash,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [skbh_pkg::HASH_W-1:0] cfg_data
);

    skbh_pkg::hash_t       bucket_count_reg;
    logic                  push_valid;
    skbh_pkg::hash_t       push_hash;
    logic                  push_ready;
    logic                  pop;
    skbh_pkg::queue_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= skbh_pkg::BUCKET_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bucket_count_reg <= cfg_data;
        end
    end

    skbh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_byte   (key_byte),
        .byte_valid (byte_valid),
        .end_of_key (end_of_key),
        .push_valid (push_valid),
        .push_hash  (push_hash),
        .push_ready (push_ready)
    );

    skbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_hash  (push_hash),
        .push_ready (push_ready),
        .pop        (pop),
        .stat       (q_stat)
    );

    skbh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (q_stat),
        .pop          (pop),
        .bucket_count (bucket_count_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_index (bucket_index),
        .full_hash    (full_hash)
    );

    // remainder stays below a nonzero bucket count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bucket_count_reg != '0) |-> (bucket_index < bucket_count_reg))
        else $error("bucket_index not below bucket_count");

    // zero bucket count passes the hash through
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bucket_count_reg == '0) |-> (bucket_index == full_hash))
        else $error("bucket_index differs from full_hash with zero bucket count");

    // a pushed hash is visible to the back end next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_ready |=> !q_stat.empty)
        else $error("queue empty after push");

    // the back end only pops a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
